[rtl/hpq_pkg.sv]
// Shared types and constants for the binary max-heap priority queue.
package hpq_pkg;

    localparam int KEY_W     = 32;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic signed [KEY_W-1:0] EMPTY_TOP = -32'sd1;

    typedef logic signed [KEY_W-1:0] t_key;

    // Decision of the shared compare unit.
    typedef struct packed {
        logic pick_b;   // second operand chosen (right child)
        logic promote;  // selected word and moving key trade places
    } t_cmp_res;

endpackage

[rtl/max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue with its sift sequencer.
//
// Usage: present i_command (0 insert i_key_in, 1 remove maximum) and
// i_key_in with start high; the word is taken at the rising edge where
// start is high and busy is low. busy then stays high until the result
// has been shown. Exactly one result word follows each command: it sits on
// o_removed_key, o_status, o_entry_count and o_top_key for one cycle with
// o_valid high, and the receiver must take it then; it cannot stall.
// Timing: a full insert, an empty remove or the remove of the only key
// strobes in the cycle after acceptance. An insert steps through S_UP_RD
// and S_UP_CMP for each level climbed; a remove passes S_LAST, then
// S_DN_RD and S_DN_CMP for each level descended. The time grows with
// log2 of the depth, set by one memory read and one compare per level
// in the shared compare unit.
// A new command is taken in the cycle after the strobe.
// Reset empties the heap (count zero); the key store itself is not
// cleared, and o_top_key reads -1 while the heap is empty.
module max_heap_priority_queue #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_command,
    input  logic signed [hpq_pkg::KEY_W-1:0]   i_key_in,
    output logic                               o_valid,
    output logic signed [hpq_pkg::KEY_W-1:0]   o_removed_key,
    output logic [hpq_pkg::STATUS_W-1:0]       o_status,
    output logic [hpq_pkg::COUNT_W-1:0]        o_entry_count,
    output logic signed [hpq_pkg::KEY_W-1:0]   o_top_key
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = CW + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LAST   = 7'b0000010,
        S_UP_RD  = 7'b0000100,
        S_UP_CMP = 7'b0001000,
        S_DN_RD  = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [AW-1:0]                   r_pos, n_pos;
    hpq_pkg::t_key                   r_key, n_key;
    hpq_pkg::t_key                   r_top, n_top;
    hpq_pkg::t_key                   r_removed, n_removed;
    logic [hpq_pkg::STATUS_W-1:0]    r_status, n_status;

    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    hpq_pkg::t_key                   w_wdata;
    logic [AW-1:0]                   w_raddr_a;
    logic [AW-1:0]                   w_raddr_b;
    hpq_pkg::t_key                   w_rdata_a;
    hpq_pkg::t_key                   w_rdata_b;
    hpq_pkg::t_key                   w_sel;
    hpq_pkg::t_cmp_res               w_cmp;

    logic [LW-1:0]                   w_lc;
    logic [LW-1:0]                   w_rc;
    logic                            w_lc_ok;
    logic                            w_rc_ok;
    logic [AW-1:0]                   w_parent;
    logic [AW-1:0]                   w_last;

    assign w_lc     = LW'({r_pos, 1'b1});
    assign w_rc     = w_lc + 1'b1;
    assign w_lc_ok  = w_lc < LW'(r_count);
    assign w_rc_ok  = w_rc < LW'(r_count);
    assign w_parent = AW'((r_pos - 1'b1) >> 1);
    assign w_last   = AW'(r_count - 1'b1);

    hpq_mem #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    hpq_cmp u_cmp (
        .i_up_mode (r_state == S_UP_CMP),
        .i_key     (r_key),
        .i_a       (w_rdata_a),
        .i_b       (w_rdata_b),
        .i_b_valid ((r_state == S_DN_CMP) && w_rc_ok),
        .o_sel     (w_sel),
        .o_res     (w_cmp)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_removed = r_removed;
        n_status  = r_status;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_key;
        w_raddr_a = AW'(w_lc);
        w_raddr_b = AW'(w_rc);

        case (r_state)
            S_IDLE: begin
                w_raddr_a = w_last;
                if (start) begin
                    n_removed = '0;
                    n_status  = hpq_pkg::STATUS_OK;
                    if (i_command == hpq_pkg::CMD_INSERT) begin
                        if (r_count >= CW'(HEAP_DEPTH)) begin
                            n_status = hpq_pkg::STATUS_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_key   = i_key_in;
                            n_pos   = AW'(r_count);
                            n_count = r_count + 1'b1;
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = hpq_pkg::STATUS_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            n_removed = r_top;
                            n_count   = r_count - 1'b1;
                            n_pos     = '0;
                            n_state   = (r_count == CW'(1)) ? S_OUT : S_LAST;
                        end
                    end
                end
            end
            S_LAST: begin
                // count is already decremented: read data is the old last word
                n_key   = w_rdata_a;
                n_state = S_DN_RD;
            end
            S_UP_RD: begin
                w_raddr_a = w_parent;
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (w_cmp.promote) begin
                    w_wdata = w_sel;
                    n_pos   = w_parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DN_RD: begin
                if (!w_lc_ok) begin
                    w_we    = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_cmp.promote) begin
                    w_wdata = w_sel;
                    n_pos   = w_cmp.pick_b ? AW'(w_rc) : AW'(w_lc);
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_top = r_top;
        if (w_we && (w_waddr == '0)) begin
            n_top = w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_top     <= n_top;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_removed_key = r_removed;
    assign o_status      = r_status;
    assign o_entry_count = hpq_pkg::COUNT_W'(r_count);
    assign o_top_key     = (r_count == '0) ? hpq_pkg::EMPTY_TOP : r_top;

endmodule

[rtl/hpq_mem.sv]
// Key store: one write port, two read ports with registered read data.
module hpq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  hpq_pkg::t_key        i_wdata,
    input  logic [AW-1:0]        i_raddr_a,
    input  logic [AW-1:0]        i_raddr_b,
    output hpq_pkg::t_key        o_rdata_a,
    output hpq_pkg::t_key        o_rdata_b
);

    hpq_pkg::t_key r_mem [DEPTH];
    hpq_pkg::t_key r_rdata_a;
    hpq_pkg::t_key r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/hpq_cmp.sv]
// Shared key compare unit: picks the larger child when sifting down and decides on a swap.
module hpq_cmp (
    input  logic               i_up_mode,
    input  hpq_pkg::t_key      i_key,
    input  hpq_pkg::t_key      i_a,
    input  hpq_pkg::t_key      i_b,
    input  logic               i_b_valid,
    output hpq_pkg::t_key      o_sel,
    output hpq_pkg::t_cmp_res  o_res
);

    logic w_pick_b;

    // equal children go right
    assign w_pick_b = i_b_valid && !(i_a > i_b);
    assign o_sel    = w_pick_b ? i_b : i_a;

    always_comb begin
        o_res.pick_b  = w_pick_b;
        o_res.promote = i_up_mode ? (i_key > o_sel) : (o_sel > i_key);
    end

endmodule
